### rtl/clipped_alpha_blend_blitter_core_defines.svh
// Assertion macros shared by the blitter RTL.
// Every check is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef CLIPPED_ALPHA_BLEND_BLITTER_CORE_DEFINES_SVH
`define CLIPPED_ALPHA_BLEND_BLITTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CABB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be true.
`define CABB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/cabb_pkg.sv
`timescale 1ns / 1ps

package cabb_pkg;

  // Largest blit or screen dimension that the clip logic honors.
  localparam logic [12:0] MaxDim = 13'd4096;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] RegScreenWidth  = 3'd0;
  localparam logic [2:0] RegScreenHeight = 3'd1;
  localparam logic [2:0] RegOriginX      = 3'd2;
  localparam logic [2:0] RegOriginY      = 3'd3;
  localparam logic [2:0] RegBlitWidth    = 3'd4;
  localparam logic [2:0] RegBlitHeight   = 3'd5;

  localparam logic [12:0] RstScreenWidth  = 13'd640;
  localparam logic [12:0] RstScreenHeight = 13'd480;
  localparam logic [12:0] RstBlitWidth    = 13'd1;
  localparam logic [12:0] RstBlitHeight   = 13'd1;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [12:0] origin_x;
    logic [12:0] origin_y;
    logic [12:0] blit_width;
    logic [12:0] blit_height;
  } cfg_t;

  // What the back end has to do with a pixel.
  typedef enum logic [1:0] {
    ClsSkip  = 2'd0,
    ClsCopy  = 2'd1,
    ClsBlend = 2'd2
  } pix_class_e;

  typedef struct packed {
    pix_class_e  cls;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [31:0] src;
    logic [31:0] bg;
    logic        row_dirty;
    logic        blit_done;
  } item_t;

  // A dimension of zero acts as one, anything above MaxDim as MaxDim.
  function automatic logic [12:0] dim_of(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > MaxDim) begin
      r = MaxDim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/clipped_alpha_blend_blitter_core.sv
`timescale 1ns / 1ps
`include "clipped_alpha_blend_blitter_core_defines.svh"

// Clipped ARGB8888 alpha-blending blitter. Source pixels come in row-major
// order, one per transfer, each with the back buffer pixel at its destination,
// and every input transfer produces exactly one output transfer carrying a
// write enable, the destination column and row, the pixel to write, a row
// dirty flag at the last column of an on-screen row, and a done flag on the
// last pixel of the blit. The block sustains one pixel per clock while the
// output is not stalled: the front end classifies a pixel in the cycle it is
// accepted and pushes it into a two-entry queue, and the back end takes it
// through a product stage and an output register, so a result is registered
// in the queue, the product stage and the output register in turn. The queue
// plus the output register let each side stall without stopping the other.
// The six 13-bit registers sit at byte addresses 0 to 20 of the APB port
// (screen width, screen height, origin x, origin y, blit width, blit height);
// they must only be written while no pixel is in flight, and the position
// counters are kept across writes.
module clipped_alpha_blend_blitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] src_pixel_i,
  input  logic [31:0] bg_pixel_i,
  // Result output.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_enable_o,
  output logic [11:0] dest_x_o,
  output logic [11:0] dest_y_o,
  output logic [31:0] pixel_out_o,
  output logic        row_dirty_o,
  output logic        blit_done_o,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cabb_pkg::cfg_t  cfg_q, cfg_d;
  cabb_pkg::item_t front_item, queue_item;
  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;
  logic [2:0]      reg_idx;
  logic [12:0]     rd_val;

  // The register file. Writes complete in the access phase; the port never
  // inserts wait states. Unknown addresses are ignored on write and read as zero.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        cabb_pkg::RegScreenWidth:  cfg_d.screen_width  = pwdata[12:0];
        cabb_pkg::RegScreenHeight: cfg_d.screen_height = pwdata[12:0];
        cabb_pkg::RegOriginX:      cfg_d.origin_x      = pwdata[12:0];
        cabb_pkg::RegOriginY:      cfg_d.origin_y      = pwdata[12:0];
        cabb_pkg::RegBlitWidth:    cfg_d.blit_width    = pwdata[12:0];
        cabb_pkg::RegBlitHeight:   cfg_d.blit_height   = pwdata[12:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cabb_pkg::RegScreenWidth:  rd_val = cfg_q.screen_width;
      cabb_pkg::RegScreenHeight: rd_val = cfg_q.screen_height;
      cabb_pkg::RegOriginX:      rd_val = cfg_q.origin_x;
      cabb_pkg::RegOriginY:      rd_val = cfg_q.origin_y;
      cabb_pkg::RegBlitWidth:    rd_val = cfg_q.blit_width;
      cabb_pkg::RegBlitHeight:   rd_val = cfg_q.blit_height;
      default:                   rd_val = 13'd0;
    endcase
  end

  assign prdata = {19'd0, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= cabb_pkg::RstScreenWidth;
      cfg_q.screen_height <= cabb_pkg::RstScreenHeight;
      cfg_q.origin_x      <= 13'd0;
      cfg_q.origin_y      <= 13'd0;
      cfg_q.blit_width    <= cabb_pkg::RstBlitWidth;
      cfg_q.blit_height   <= cabb_pkg::RstBlitHeight;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: position tracking, clipping and classification.
  cabb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .src_pixel_i  (src_pixel_i),
    .bg_pixel_i   (bg_pixel_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .item_o       (front_item)
  );

  // Decoupling queue.
  cabb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (queue_item)
  );

  // Back end: blend arithmetic and the output register.
  cabb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .item_i         (queue_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .dest_x_o       (dest_x_o),
    .dest_y_o       (dest_y_o),
    .pixel_out_o    (pixel_out_o),
    .row_dirty_o    (row_dirty_o),
    .blit_done_o    (blit_done_o)
  );

  // Every written pixel is opaque, whether copied or blended.
  `CABB_ASSERT_NEVER(a_written_alpha_opaque, out_valid_o && write_enable_o && (pixel_out_o[31:24] != 8'hFF), "written pixel is not opaque")
  // A pixel that is not written carries no color.
  `CABB_ASSERT_IMP(a_skip_pixel_zero, out_valid_o && !write_enable_o, pixel_out_o == 32'd0, "skipped pixel has nonzero data")
  // Writes land inside the configured screen.
  `CABB_ASSERT_IMP(a_write_on_screen, out_valid_o && write_enable_o, ({1'b0, dest_x_o} < cabb_pkg::dim_of(cfg_q.screen_width)) && ({1'b0, dest_y_o} < cabb_pkg::dim_of(cfg_q.screen_height)), "write outside the screen")

endmodule

### rtl/cabb_front.sv
`timescale 1ns / 1ps

// Tracks the position inside the blit, clips it and classifies each pixel.
module cabb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       src_pixel_i,
  input  logic [31:0]       bg_pixel_i,
  input  cabb_pkg::cfg_t    cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output cabb_pkg::item_t   item_o
);

  logic [11:0] col_q, col_d;
  logic [11:0] row_q, row_d;

  logic [12:0] sw, sh, bw, bh;
  logic signed [13:0] dx, dy;
  logic row_on, on, last_col, last_row;
  logic [7:0] alpha;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    sw = cabb_pkg::dim_of(cfg_i.screen_width);
    sh = cabb_pkg::dim_of(cfg_i.screen_height);
    bw = cabb_pkg::dim_of(cfg_i.blit_width);
    bh = cabb_pkg::dim_of(cfg_i.blit_height);
    dx = $signed({cfg_i.origin_x[12], cfg_i.origin_x}) + $signed({2'b00, col_q});
    dy = $signed({cfg_i.origin_y[12], cfg_i.origin_y}) + $signed({2'b00, row_q});
    row_on = (dy >= 14'sd0) && (dy < $signed({1'b0, sh}));
    on = row_on && (dx >= 14'sd0) && (dx < $signed({1'b0, sw}));
    last_col = {1'b0, col_q} >= (bw - 13'd1);
    last_row = {1'b0, row_q} >= (bh - 13'd1);
    alpha = src_pixel_i[31:24];

    item_o.src       = src_pixel_i;
    item_o.bg        = bg_pixel_i;
    item_o.row_dirty = row_on && last_col;
    item_o.blit_done = last_col && last_row;
    if (on) begin
      item_o.dest_x = dx[11:0];
      item_o.dest_y = dy[11:0];
      if (alpha == 8'hFF) begin
        item_o.cls = cabb_pkg::ClsCopy;
      end else if (alpha == 8'h00) begin
        item_o.cls = cabb_pkg::ClsSkip;
      end else begin
        item_o.cls = cabb_pkg::ClsBlend;
      end
    end else begin
      item_o.dest_x = 12'd0;
      item_o.dest_y = 12'd0;
      item_o.cls    = cabb_pkg::ClsSkip;
    end

    col_d = col_q;
    row_d = row_q;
    if (in_valid_i && in_ready_o) begin
      if (last_col) begin
        col_d = 12'd0;
        row_d = last_row ? 12'd0 : row_q + 12'd1;
      end else begin
        col_d = col_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 12'd0;
      row_q <= 12'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### rtl/cabb_queue.sv
`timescale 1ns / 1ps

// Two-entry queue between the front and the back end.
module cabb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  cabb_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output cabb_pkg::item_t pop_item_o
);

  cabb_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/cabb_back.sv
`timescale 1ns / 1ps

// Blend pipeline: channel products, then sum and divide by 255 into the output register.
module cabb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  cabb_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            write_enable_o,
  output logic [11:0]     dest_x_o,
  output logic [11:0]     dest_y_o,
  output logic [31:0]     pixel_out_o,
  output logic            row_dirty_o,
  output logic            blit_done_o
);

  // Product stage.
  logic            s1_valid_q, s1_valid_d;
  cabb_pkg::item_t s1_item_q;
  logic [15:0]     s1_prod_s_q [3];
  logic [15:0]     s1_prod_b_q [3];
  logic [15:0]     prod_s [3];
  logic [15:0]     prod_b [3];

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        we_q;
  logic [11:0] dest_x_q, dest_y_q;
  logic [31:0] pixel_q, pixel_d;
  logic        row_dirty_q, blit_done_q;

  logic        s1_ready, s2_ready;
  logic [16:0] sum [3];
  logic [16:0] quo [3];
  logic [7:0]  chan [3];
  logic [7:0]  alpha, bg_weight;

  assign s2_ready    = !out_valid_q || out_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign pop_ready_o = s1_ready;

  always_comb begin
    alpha     = item_i.src[31:24];
    bg_weight = 8'd255 - alpha;
    for (int c = 0; c < 3; c++) begin
      prod_s[c] = {8'd0, item_i.src[8*c +: 8]} * {8'd0, alpha};
      prod_b[c] = {8'd0, item_i.bg[8*c +: 8]} * {8'd0, bg_weight};
    end
  end

  // x / 255 for x below 65536 equals (x + 1 + (x >> 8)) >> 8.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c]  = {1'b0, s1_prod_s_q[c]} + {1'b0, s1_prod_b_q[c]};
      quo[c]  = sum[c] + 17'd1 + {9'd0, sum[c][15:8]};
      chan[c] = quo[c][15:8];
    end
    case (s1_item_q.cls)
      cabb_pkg::ClsCopy:  pixel_d = s1_item_q.src;
      cabb_pkg::ClsBlend: pixel_d = {8'hFF, chan[2], chan[1], chan[0]};
      default:            pixel_d = 32'd0;
    endcase
  end

  assign s1_valid_d  = s1_ready ? pop_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && s1_ready) begin
      s1_item_q <= item_i;
      for (int c = 0; c < 3; c++) begin
        s1_prod_s_q[c] <= prod_s[c];
        s1_prod_b_q[c] <= prod_b[c];
      end
    end
    if (s1_valid_q && s2_ready) begin
      we_q        <= (s1_item_q.cls != cabb_pkg::ClsSkip);
      dest_x_q    <= s1_item_q.dest_x;
      dest_y_q    <= s1_item_q.dest_y;
      pixel_q     <= pixel_d;
      row_dirty_q <= s1_item_q.row_dirty;
      blit_done_q <= s1_item_q.blit_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign dest_x_o       = dest_x_q;
  assign dest_y_o       = dest_y_q;
  assign pixel_out_o    = pixel_q;
  assign row_dirty_o    = row_dirty_q;
  assign blit_done_o    = blit_done_q;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

// Testbench for the clipped ARGB8888 alpha-blending blitter.
//
// A stimulus process walks a short directed plan, then runs randomized phases.
// Each phase retunes all six registers over the register port while the block
// is drained, reads them back, and then streams random pixels. Every accepted
// input transfer is run through a local model of the blitter. The model keeps
// its own copy of the registers and of the column and row counters. The
// expected result is queued, and a monitor checks each output transfer against
// the oldest queued result, one field at a time.
module tb;

  // Indexes past the last register. Writes to them must be ignored.
  localparam logic [2:0] RegSpareA = 3'd6;
  localparam logic [2:0] RegSpareB = 3'd7;

  localparam int RandomPixels = 1650;

  // One output transfer, in the order of the output ports.
  typedef struct packed {
    logic        write_enable;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [31:0] pixel_out;
    logic        row_dirty;
    logic        blit_done;
  } blit_result_t;

  typedef enum logic [1:0] {
    RowPixel,
    RowWrite,
    RowRead
  } plan_kind_e;

  // One step of the directed plan. A pixel row with a golden result uses that
  // result in place of the model's answer. The model still advances so that
  // its counters stay in step with the block.
  typedef struct packed {
    plan_kind_e   kind;
    logic [2:0]   reg_idx;
    logic [31:0]  word_a;
    logic [31:0]  word_b;
    logic         golden;
    blit_result_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] src_pixel_i;
  logic [31:0] bg_pixel_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        write_enable_o;
  logic [11:0] dest_x_o;
  logic [11:0] dest_y_o;
  logic [31:0] pixel_out_o;
  logic        row_dirty_o;
  logic        blit_done_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // The model's copy of the registers, indexed by register code, and its
  // position inside the current blit.
  logic [12:0] cfg_shadow [6];
  int          col_pos;
  int          row_pos;

  blit_result_t pixels_due[$];
  plan_row_t    plan[$];
  int           fail_count = 0;

  // When set, the sender sends back to back and the receiver never stalls.
  bit           steady_flow = 1'b0;
  int unsigned  hold_cnt = 0;

  clipped_alpha_blend_blitter_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .src_pixel_i    (src_pixel_i),
    .bg_pixel_i     (bg_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .dest_x_o       (dest_x_o),
    .dest_y_o       (dest_y_o),
    .pixel_out_o    (pixel_out_o),
    .row_dirty_o    (row_dirty_o),
    .blit_done_o    (blit_done_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // A dimension of zero counts as one, and anything above the maximum counts
  // as the maximum.
  function automatic int span_of(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > cabb_pkg::MaxDim) return cabb_pkg::MaxDim;
    return v;
  endfunction

  function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] b,
                                      input logic [7:0] a);
    int si;
    int bi;
    int ai;
    si = s;
    bi = b;
    ai = a;
    return 8'((si * ai + bi * (255 - ai)) / 255);
  endfunction

  // Works out the result of one pixel and moves the blit position on by one
  // pixel, exactly as the block does on an input transfer.
  function automatic blit_result_t next_blit_pixel(input logic [31:0] src,
                                                   input logic [31:0] bg);
    blit_result_t r;
    int sw;
    int sh;
    int bw;
    int bh;
    int ox;
    int oy;
    int dx;
    int dy;
    bit row_on;
    bit last_col;
    bit last_row;
    sw = span_of(cfg_shadow[cabb_pkg::RegScreenWidth]);
    sh = span_of(cfg_shadow[cabb_pkg::RegScreenHeight]);
    bw = span_of(cfg_shadow[cabb_pkg::RegBlitWidth]);
    bh = span_of(cfg_shadow[cabb_pkg::RegBlitHeight]);
    ox = $signed(cfg_shadow[cabb_pkg::RegOriginX]);
    oy = $signed(cfg_shadow[cabb_pkg::RegOriginY]);
    dx = ox + col_pos;
    dy = oy + row_pos;
    row_on = (dy >= 0) && (dy < sh);
    // A counter left past the end by a register change still counts as the
    // last column or the last row.
    last_col = col_pos >= bw - 1;
    last_row = row_pos >= bh - 1;
    r = '0;
    if (row_on && dx >= 0 && dx < sw) begin
      r.dest_x = 12'(dx);
      r.dest_y = 12'(dy);
      if (src[31:24] == 8'hFF) begin
        r.write_enable = 1'b1;
        r.pixel_out = src;
      end else if (src[31:24] != 8'h00) begin
        r.write_enable = 1'b1;
        r.pixel_out = {8'hFF, mix8(src[23:16], bg[23:16], src[31:24]),
                       mix8(src[15:8], bg[15:8], src[31:24]),
                       mix8(src[7:0], bg[7:0], src[31:24])};
      end
    end
    r.row_dirty = row_on && last_col;
    r.blit_done = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (fail_count < 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
      fail_count++;
    end
  endtask

  // Gap lengths: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Screen and blit sizes stay small most of the time so that clipping, row
  // ends and blit ends come often. The zero, maximum and oversize values are
  // mixed in among them.
  function automatic logic [31:0] pick_extent(input bit for_screen);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return for_screen ? $urandom_range(1, 12) : $urandom_range(1, 6);
    if (r < 68) return 32'd0;
    if (r < 76) return 32'd4096;
    if (r < 84) return 32'd8191;
    return $urandom();
  endfunction

  // Origins sit near the screen most of the time. A negative origin carries
  // set upper bits in the write data, which the register must drop.
  function automatic logic [31:0] pick_origin();
    int r;
    int o;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      o = $urandom_range(0, 16);
      return o - 6;
    end
    if (r < 78) return -4096;
    if (r < 86) return 4095;
    return $urandom();
  endfunction

  // The register port has a setup phase and an access phase. The access
  // completes at the edge where pready is seen high, and the bus then goes idle
  // so that the next access starts cleanly.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] word);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= cabb_pkg::RegBlitHeight) cfg_shadow[idx] = word[12:0];
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [2:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("register readback", {19'd0, cfg_shadow[idx]}, {19'd0, prdata[12:0]});
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Presents one pixel and holds it until the transfer happens. Valid stays
  // high on return, so a following pixel can go out in the very next cycle.
  task automatic send_pixel(input logic [31:0] src, input logic [31:0] bg,
                            input logic golden, input blit_result_t want);
    blit_result_t model;
    in_valid_i <= 1'b1;
    src_pixel_i <= src;
    bg_pixel_i <= bg;
    do @(posedge clk_i); while (!in_ready_o);
    model = next_blit_pixel(src, bg);
    pixels_due.push_back(golden ? want : model);
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stops sending, waits until every queued result has come back, and then
  // lets the two-stage pipeline settle before anything else happens.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_pixel(input logic [31:0] src, input logic [31:0] bg);
    plan_row_t row;
    row = '0;
    row.kind = RowPixel;
    row.word_a = src;
    row.word_b = bg;
    plan.push_back(row);
  endtask

  task automatic add_golden(input logic [31:0] src, input logic [31:0] bg,
                            input blit_result_t want);
    plan_row_t row;
    row = '0;
    row.kind = RowPixel;
    row.word_a = src;
    row.word_b = bg;
    row.golden = 1'b1;
    row.want = want;
    plan.push_back(row);
  endtask

  task automatic add_access(input plan_kind_e kind, input logic [2:0] idx,
                            input logic [31:0] word);
    plan_row_t row;
    row = '0;
    row.kind = kind;
    row.reg_idx = idx;
    row.word_a = word;
    plan.push_back(row);
  endtask

  // New settings for the next phase. Every register gets written, and the
  // readback confirms what the model now holds.
  task automatic retune_blit();
    int i;
    apb_write(cabb_pkg::RegScreenWidth, pick_extent(1'b1));
    apb_write(cabb_pkg::RegScreenHeight, pick_extent(1'b1));
    apb_write(cabb_pkg::RegOriginX, pick_origin());
    apb_write(cabb_pkg::RegOriginY, pick_origin());
    apb_write(cabb_pkg::RegBlitWidth, pick_extent(1'b0));
    apb_write(cabb_pkg::RegBlitHeight, pick_extent(1'b0));
    if ($urandom_range(0, 4) == 0) begin
      apb_write($urandom_range(0, 1) ? RegSpareA : RegSpareB, $urandom());
    end
    for (i = cabb_pkg::RegScreenWidth; i <= cabb_pkg::RegBlitHeight; i++) begin
      apb_read_check(3'(i));
    end
  endtask

  // The receiver stalls at random, and one stall in ten is much longer than
  // the others.
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!steady_flow && $urandom_range(0, 99) < 30) begin
      out_ready_i <= 1'b0;
      hold_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                              : $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every output transfer is checked against the oldest expected result.
  always @(posedge clk_i) begin : result_check
    blit_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixels_due.size() == 0) begin
        if (fail_count < 10) begin
          $display("%0t: output transfer with no result expected", $time);
        end
        fail_count++;
      end else begin
        want = pixels_due.pop_front();
        check_field("write_enable", {31'd0, want.write_enable}, {31'd0, write_enable_o});
        check_field("dest_x", {20'd0, want.dest_x}, {20'd0, dest_x_o});
        check_field("dest_y", {20'd0, want.dest_y}, {20'd0, dest_y_o});
        check_field("pixel_out", want.pixel_out, pixel_out_o);
        check_field("row_dirty", {31'd0, want.row_dirty}, {31'd0, row_dirty_o});
        check_field("blit_done", {31'd0, want.blit_done}, {31'd0, blit_done_o});
      end
    end
  end

  initial begin : stimulus
    int i;
    int sent;
    int burst;
    int k;
    int r;
    logic [7:0]  alpha;
    logic [31:0] src;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    src_pixel_i <= '0;
    bg_pixel_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_shadow[cabb_pkg::RegScreenWidth] = cabb_pkg::RstScreenWidth;
    cfg_shadow[cabb_pkg::RegScreenHeight] = cabb_pkg::RstScreenHeight;
    cfg_shadow[cabb_pkg::RegOriginX] = '0;
    cfg_shadow[cabb_pkg::RegOriginY] = '0;
    cfg_shadow[cabb_pkg::RegBlitWidth] = cabb_pkg::RstBlitWidth;
    cfg_shadow[cabb_pkg::RegBlitHeight] = cabb_pkg::RstBlitHeight;
    col_pos = 0;
    row_pos = 0;

    // After reset the screen is 640x480 and the blit is one pixel at the
    // origin. Every pixel then lands at (0,0) as the last column of an
    // on-screen row and the last pixel of the blit. The golden results cover
    // an opaque pixel, a transparent one, and blends at mid, lowest and
    // highest alpha. The alpha of the background has no effect.
    add_golden(32'hFF123456, 32'h00000000, {1'b1, 24'd0, 32'hFF123456, 2'b11});
    add_golden(32'h00ABCDEF, 32'hFFFFFFFF, {1'b0, 24'd0, 32'h00000000, 2'b11});
    add_golden(32'h80FF0000, 32'h0000FF00, {1'b1, 24'd0, 32'hFF807F00, 2'b11});
    add_golden(32'h01FFFFFF, 32'h00000000, {1'b1, 24'd0, 32'hFF010101, 2'b11});
    add_golden(32'hFE000000, 32'hFFFFFFFF, {1'b1, 24'd0, 32'hFF010101, 2'b11});
    add_golden(32'hFFFFFFFF, 32'hFFFFFFFF, {1'b1, 24'd0, 32'hFFFFFFFF, 2'b11});

    // A 3x2 blit one column left of the screen. Its first pixel is clipped,
    // so every output field is zero.
    add_access(RowWrite, cabb_pkg::RegOriginX, 32'h00001FFF);
    add_access(RowWrite, cabb_pkg::RegBlitWidth, 32'd3);
    add_access(RowWrite, cabb_pkg::RegBlitHeight, 32'd2);
    add_golden(32'hFFABCDEF, 32'h12345678, {1'b1 ^ 1'b1, 24'd0, 32'h0, 2'b00});
    add_pixel(32'hFF00FF00, 32'h55AA55AA);
    add_pixel(32'h7F336699, 32'hCCCCCCCC);
    add_pixel(32'h00FFFFFF, 32'h0F0F0F0F);
    add_pixel(32'hC0800080, 32'h80008000);
    add_pixel(32'h40FFFFFF, 32'h00000000);

    // With all dimensions zero, every dimension counts as one.
    add_access(RowWrite, cabb_pkg::RegScreenWidth, 32'd0);
    add_access(RowWrite, cabb_pkg::RegScreenHeight, 32'd0);
    add_access(RowWrite, cabb_pkg::RegOriginX, 32'd0);
    add_access(RowWrite, cabb_pkg::RegOriginY, 32'd0);
    add_access(RowWrite, cabb_pkg::RegBlitWidth, 32'd0);
    add_access(RowWrite, cabb_pkg::RegBlitHeight, 32'd0);
    add_golden(32'hFF00FF00, 32'hFFFFFFFF, {1'b1, 24'd0, 32'hFF00FF00, 2'b11});
    add_pixel(32'h40A0B0C0, 32'h10203040);

    // Oversize dimensions count as the maximum. The blit starts at the far
    // corner, so its second column falls just off the right edge.
    add_access(RowWrite, cabb_pkg::RegScreenWidth, 32'd8191);
    add_access(RowWrite, cabb_pkg::RegScreenHeight, 32'd4096);
    add_access(RowWrite, cabb_pkg::RegOriginX, 32'd4095);
    add_access(RowWrite, cabb_pkg::RegOriginY, 32'd4095);
    add_access(RowWrite, cabb_pkg::RegBlitWidth, 32'd8191);
    add_access(RowWrite, cabb_pkg::RegBlitHeight, 32'd2);
    add_pixel(32'hFFFEDCBA, 32'h00000000);
    add_pixel(32'hFF010203, 32'h00000000);

    // Narrowing the blit in the middle of a row makes the current column the
    // last one. The second row is then placed far above the screen.
    add_access(RowWrite, cabb_pkg::RegBlitWidth, 32'd2);
    add_pixel(32'hFF445566, 32'h00000000);
    add_access(RowWrite, cabb_pkg::RegOriginY, 32'h00001000);
    add_access(RowWrite, cabb_pkg::RegOriginX, 32'h00001000);
    add_pixel(32'hFF778899, 32'h00000000);
    add_pixel(32'h99778899, 32'h11223344);

    // Writes to indexes past the last register change nothing. Upper write
    // data bits are dropped.
    add_access(RowWrite, RegSpareA, 32'hFFFFFFFF);
    add_access(RowWrite, RegSpareB, 32'h00000000);
    add_access(RowWrite, cabb_pkg::RegOriginX, 32'hFFFFE005);
    add_access(RowWrite, cabb_pkg::RegOriginY, 32'd0);
    add_access(RowRead, cabb_pkg::RegScreenWidth, 32'd0);
    add_access(RowRead, cabb_pkg::RegScreenHeight, 32'd0);
    add_access(RowRead, cabb_pkg::RegOriginX, 32'd0);
    add_access(RowRead, cabb_pkg::RegOriginY, 32'd0);
    add_access(RowRead, cabb_pkg::RegBlitWidth, 32'd0);
    add_access(RowRead, cabb_pkg::RegBlitHeight, 32'd0);
    add_pixel(32'hFF0A0B0C, 32'h00000000);
    add_pixel(32'h20FFFFFF, 32'h00808080);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers are only touched after every pixel in flight has come back.
    for (i = 0; i < plan.size(); i++) begin
      case (plan[i].kind)
        RowWrite: begin
          drain_results();
          apb_write(plan[i].reg_idx, plan[i].word_a);
        end
        RowRead: begin
          drain_results();
          apb_read_check(plan[i].reg_idx);
        end
        default: begin
          send_pixel(plan[i].word_a, plan[i].word_b, plan[i].golden, plan[i].want);
          idle_input(pick_gap());
        end
      endcase
    end

    // Random phases. Each phase starts from new settings, and the blit
    // position carries over from the phase before. About one phase in four
    // runs with no gaps and no stalls. The sender now and then also pauses
    // until every result is back.
    sent = 0;
    while (sent < RandomPixels) begin
      drain_results();
      retune_blit();
      steady_flow = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(40, 160);
      for (k = 0; k < burst && sent < RandomPixels; k++) begin
        r = $urandom_range(0, 99);
        if (r < 20) alpha = 8'h00;
        else if (r < 40) alpha = 8'hFF;
        else if (r < 45) alpha = 8'h01;
        else if (r < 50) alpha = 8'hFE;
        else alpha = $urandom_range(0, 255);
        src = $urandom();
        src[31:24] = alpha;
        send_pixel(src, $urandom(), 1'b0, '0);
        sent++;
        if ($urandom_range(0, 99) < 2) drain_results();
        else idle_input(pick_gap());
      end
    end
    steady_flow = 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && pixels_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // A healthy run needs well under a quarter of this time, even with every
  // pixel meeting the longest gap and the longest stall.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/cabb_pkg.sv
rtl/cabb_front.sv
rtl/cabb_queue.sv
rtl/cabb_back.sv
rtl/clipped_alpha_blend_blitter_core.sv
bench/tb.sv
